// ===== hdl/lru_tag_cache_lookup_core_defines.svh =====
// ============================================================================
// lru tag cache lookup - assertion macros
// concurrent checks on the core clock, masked while reset is high
// ============================================================================
`ifndef LRU_TAG_CACHE_LOOKUP_CORE_DEFINES_SVH
`define LRU_TAG_CACHE_LOOKUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LTC_ASSERT_IMPLIES(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("lru tag cache: same-cycle check failed");

// next-cycle implication
`define LTC_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("lru tag cache: next-cycle check failed");

// invariant
`define LTC_ASSERT_ALWAYS(label, prop) \
   `LTC_ASSERT_IMPLIES(label, 1'b1, prop)

`else

`define LTC_ASSERT_IMPLIES(label, cond, prop)
`define LTC_ASSERT_NEXT(label, cond, prop)
`define LTC_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== hdl/ltc_pkg.sv =====
// ============================================================================
// ltc_pkg
// shared constants, token and write types, state enum and offset helper
// ============================================================================
package ltc_pkg;

   localparam int CACHE_SLOTS  = 32;
   localparam int IDX_W        = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
   localparam int CNT_W        = $clog2(CACHE_SLOTS + 1);

   localparam int TEXTURE_W    = 8;
   localparam int TAG_W        = 9;
   localparam int STAMP_W      = 16;
   localparam int AGE_W        = STAMP_W - 1;
   localparam int SLOT_W       = 5;
   localparam int OFFSET_W     = 15;

   localparam int TILE_COLUMNS = 8;
   localparam int ROW_BYTES    = 256;
   localparam int TILE_BYTES   = 32;
   localparam int COLUMN_MASK  = 7;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic             hit;
      logic [AGE_W-1:0] best_age;
      logic [IDX_W-1:0] idx;
   } token_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [TAG_W-1:0] tag;
   } write_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   function automatic logic [OFFSET_W-1:0] offset_of(input logic [IDX_W-1:0] s);
      logic [31:0] wide;
      logic [31:0] off;
      begin
         wide = 32'(s);
         off  = (wide / TILE_COLUMNS) * ROW_BYTES * TILE_BYTES
              + (wide & 32'(COLUMN_MASK)) * TILE_BYTES;
         offset_of = off[OFFSET_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/lru_tag_cache_lookup_core.sv =====
// ============================================================================
// lru_tag_cache_lookup_core
// fully associative texture tag cache with timestamp lru replacement
// ============================================================================
//  channel   direction   handshake            payload
//  req       in          req_valid/req_stall  req_texture_id, req_vertical
//  rsp       out         rsp_valid/rsp_stall  rsp_hit, rsp_slot, rsp_data_offset
//
//  one request at a time: the request token walks the slot cells one per cycle, then
//  the commit state registers the result and raises rsp_valid, and the next request
//  beat is taken once the commit has been made
//  the result register frees the scanner while a result waits on rsp_stall
//  a stalled result holds the commit stage, req_stall stays high meanwhile
//  synchronous reset empties the cache and clears the use counter
// ============================================================================
`include "lru_tag_cache_lookup_core_defines.svh"

module lru_tag_cache_lookup_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ltc_pkg::TEXTURE_W-1:0] req_texture_id,
   input  logic                          req_vertical,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [ltc_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [ltc_pkg::OFFSET_W-1:0]  rsp_data_offset
);
   import ltc_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [STAMP_W-1:0] ctr_ff, ctr_in;
   token_type          res_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [OFFSET_W-1:0] rsp_data_offset_ff;

   token_type          tok [0:CACHE_SLOTS];
   write_type          wr;
   logic               accept;
   logic               commit;
   logic               not_full;
   logic [IDX_W-1:0]   victim;

   // token injection
   always_comb begin
      tok[0].valid    = accept;
      tok[0].tag      = {req_vertical, req_texture_id};
      tok[0].hit      = 1'b0;
      tok[0].best_age = '0;
      tok[0].idx      = '0;
   end

   for (genvar i = 0; i < CACHE_SLOTS; i++) begin : g_cell
      ltc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(i)),
         .cell_used (CNT_W'(i) < used_ff),
         .counter   (ctr_ff),
         .wr        (wr),
         .tok_i     (tok[i]),
         .tok_o     (tok[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (tok[CACHE_SLOTS].valid) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SCAN:   commit    = 1'b0;
         ST_COMMIT: commit    = !rsp_valid_ff || !rsp_stall;
         default:   req_stall = 1'b1;
      endcase
   end

   assign accept   = req_valid && !req_stall;
   assign not_full = used_ff < CNT_W'(CACHE_SLOTS);
   assign victim   = (!res_ff.hit && not_full) ? used_ff[IDX_W-1:0] : res_ff.idx;

   always_comb begin
      wr.en  = commit;
      wr.idx = victim;
      wr.tag = res_ff.tag;
   end

   always_comb begin
      used_in      = used_ff;
      ctr_in       = ctr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (commit) begin
         ctr_in       = ctr_ff + 1'b1;
         rsp_valid_in = 1'b1;
         if (!res_ff.hit && not_full) used_in = used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && tok[CACHE_SLOTS].valid) begin
         res_ff <= tok[CACHE_SLOTS];
      end
      if (commit) begin
         rsp_hit_ff         <= res_ff.hit;
         rsp_slot_ff        <= SLOT_W'(victim);
         rsp_data_offset_ff <= offset_of(victim);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_data_offset = rsp_data_offset_ff;

   `LTC_ASSERT_ALWAYS(a_used_bound, used_ff <= CNT_W'(CACHE_SLOTS))
   `LTC_ASSERT_NEXT(a_accept_scan, accept, state_ff == ST_SCAN)
   `LTC_ASSERT_IMPLIES(a_token_in_scan, tok[CACHE_SLOTS].valid, state_ff == ST_SCAN)
   `LTC_ASSERT_NEXT(a_counter_step, commit, ctr_ff == $past(ctr_ff) + 16'd1)
   `LTC_ASSERT_NEXT(a_fill_step, commit && !res_ff.hit && not_full,
                    used_ff == $past(used_ff) + 1'b1)

endmodule

// ===== hdl/ltc_cell.sv =====
// ============================================================================
// ltc_cell
// one cache slot: holds tag and stamp, checks the passing token for a match
// and for the oldest positive age, then hands it on to the next cell
// ============================================================================
module ltc_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ltc_pkg::IDX_W-1:0]   cell_idx,
   input  logic                     cell_used,
   input  logic [ltc_pkg::STAMP_W-1:0] counter,
   input  ltc_pkg::write_type       wr,
   input  ltc_pkg::token_type       tok_i,
   output ltc_pkg::token_type       tok_o
);
   import ltc_pkg::*;

   logic [TAG_W-1:0]   tag_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [STAMP_W-1:0] age;
   token_type          tok_ff;
   token_type          tok_in;

   always_comb begin
      age    = counter - stamp_ff;
      tok_in = tok_i;
      if (tok_i.valid && cell_used && !tok_i.hit) begin
         if (tag_ff == tok_i.tag) begin
            tok_in.hit = 1'b1;
            tok_in.idx = cell_idx;
         end else if (!age[STAMP_W-1] && (age[AGE_W-1:0] > tok_i.best_age)) begin
            tok_in.best_age = age[AGE_W-1:0];
            tok_in.idx      = cell_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == cell_idx)) begin
         tag_ff   <= wr.tag;
         stamp_ff <= counter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.tag      <= tok_in.tag;
      tok_ff.hit      <= tok_in.hit;
      tok_ff.best_age <= tok_in.best_age;
      tok_ff.idx      <= tok_in.idx;
   end

   assign tok_o = tok_ff;

endmodule

// ===== dv/lru_tag_cache_lookup_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// lru_tag_cache_lookup_checker
// tracks its own copy of the tag store and the stamps for every accepted
// request beat, works out hit, slot and offset, and compares each result
// beat in order against the oldest outstanding prediction
// ============================================================================
module lru_tag_cache_lookup_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [ltc_pkg::TEXTURE_W-1:0] req_texture_id,
   input  logic                          req_vertical,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_hit,
   input  logic [ltc_pkg::SLOT_W-1:0]    rsp_slot,
   input  logic [ltc_pkg::OFFSET_W-1:0]  rsp_data_offset,
   output int                            fail_count,
   output int                            outstanding,
   output int                            hit_count,
   output int                            miss_count,
   output int                            evict_count,
   output int                            aged_out_count
);
   import ltc_pkg::*;

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic [OFFSET_W-1:0] data_offset;
   } lookup_result_type;

   logic [TAG_W-1:0]   cached_tag [CACHE_SLOTS];
   logic [STAMP_W-1:0] last_use   [CACHE_SLOTS];
   int                 filled;
   logic [STAMP_W-1:0] use_count;
   lookup_result_type  pending_lookups [$];
   int                 errors;
   int                 hits;
   int                 misses;
   int                 evictions;
   int                 aged_outs;

   function automatic lookup_result_type lookup_and_update(input logic [TAG_W-1:0] tag);
      lookup_result_type  result;
      logic [STAMP_W-1:0] age;
      logic [STAMP_W-1:0] oldest;
      int                 victim;
      int                 found;
      int                 offset;
      int                 i;
      bit                 saw_negative;
      found        = -1;
      victim       = 0;
      oldest       = '0;
      saw_negative = 1'b0;
      for (i = 0; i < filled && found < 0; i++) begin
         if (cached_tag[i] == tag) begin
            found = i;
         end else begin
            age = use_count - last_use[i];
            // signed age: top bit set means the stamp is ahead after a wrap
            if (age[STAMP_W-1]) begin
               saw_negative = 1'b1;
            end else if (age > oldest) begin
               oldest = age;
               victim = i;
            end
         end
      end
      if (found >= 0) begin
         victim = found;
         hits++;
      end else begin
         misses++;
         if (filled < CACHE_SLOTS) begin
            victim = filled;
            filled++;
         end else begin
            evictions++;
            if (saw_negative) aged_outs++;
         end
      end
      cached_tag[victim] = tag;
      last_use[victim]   = use_count;
      use_count++;
      offset = (victim / TILE_COLUMNS) * ROW_BYTES * TILE_BYTES
             + (victim % TILE_COLUMNS) * TILE_BYTES;
      result.hit         = (found >= 0);
      result.slot        = victim[SLOT_W-1:0];
      result.data_offset = offset[OFFSET_W-1:0];
      return result;
   endfunction

   always @(posedge clock) begin : monitor
      lookup_result_type want;
      if (reset) begin
         filled    = 0;
         use_count = '0;
         pending_lookups.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_lookups.size() == 0) begin
               errors++;
               $display({"%0t: result beat with nothing pending: expected none, ",
                         "got hit %0d slot %0d offset %0d"},
                        $time, rsp_hit, rsp_slot, rsp_data_offset);
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_hit !== want.hit) begin
                  errors++;
                  $display("%0t: hit mismatch: expected %0d, got %0d", $time, want.hit, rsp_hit);
               end
               if (rsp_slot !== want.slot) begin
                  errors++;
                  $display("%0t: slot mismatch: expected %0d, got %0d", $time, want.slot, rsp_slot);
               end
               if (rsp_data_offset !== want.data_offset) begin
                  errors++;
                  $display("%0t: data_offset mismatch: expected %0d, got %0d",
                           $time, want.data_offset, rsp_data_offset);
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_lookups.push_back(lookup_and_update({req_vertical, req_texture_id}));
         end
      end
      fail_count     <= errors;
      outstanding    <= pending_lookups.size();
      hit_count      <= hits;
      miss_count     <= misses;
      evict_count    <= evictions;
      aged_out_count <= aged_outs;
   end

endmodule

// ===== dv/tb_lru_tag_cache_lookup_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_lru_tag_cache_lookup_core
// drives texture lookups through the lru tag cache: edge tags and early hits,
// random traffic over a working set under sender and receiver idling, and a
// long receiver hold-off that backs the block up to its input
// ============================================================================
module tb_lru_tag_cache_lookup_core;
   import ltc_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int WORKING_SET  = 40;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 4000000;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [TEXTURE_W-1:0]  req_texture_id = '0;
   logic                  req_vertical   = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic                  rsp_hit;
   logic [SLOT_W-1:0]     rsp_slot;
   logic [OFFSET_W-1:0]   rsp_data_offset;

   int                    fail_count;
   int                    outstanding;
   int                    hit_count;
   int                    miss_count;
   int                    evict_count;
   int                    aged_out_count;

   int                    gap_pct        = 0;
   int                    stall_pct      = 0;
   logic                  hold_armed     = 1'b0;
   bit                    hold_taken     = 1'b0;
   int                    hold_left      = 0;
   int                    cycle_count    = 0;
   logic [TAG_W-1:0]      working_tags [WORKING_SET];

   lru_tag_cache_lookup_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_texture_id  (req_texture_id),
      .req_vertical    (req_vertical),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_data_offset (rsp_data_offset)
   );

   lru_tag_cache_lookup_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_texture_id  (req_texture_id),
      .req_vertical    (req_vertical),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_data_offset (rsp_data_offset),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .hit_count       (hit_count),
      .miss_count      (miss_count),
      .evict_count     (evict_count),
      .aged_out_count  (aged_out_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off once armed
   always @(posedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one request beat, held until accepted
   task automatic offer(input logic [TEXTURE_W-1:0] texture, input logic vertical);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_texture_id <= texture;
      req_vertical   <= vertical;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly a drifting working set so hits and lru evictions both happen
   task automatic offer_random();
      logic [TAG_W-1:0] tag;
      int               k;
      if ($urandom_range(99) < 70) begin
         k = $urandom_range(WORKING_SET - 1);
         if ($urandom_range(99) < 3) working_tags[k] = TAG_W'($urandom_range(511));
         tag = working_tags[k];
      end else begin
         tag = TAG_W'($urandom_range(511));
      end
      offer(tag[TEXTURE_W-1:0], tag[TAG_W-1]);
   endtask

   initial begin : stimulus
      int n;
      for (n = 0; n < WORKING_SET; n++) working_tags[n] = TAG_W'($urandom_range(511));
      repeat (6) @(posedge clock);
      reset     <= 1'b0;
      gap_pct    = 10;
      stall_pct <= 76;

      // edge tags, tags differing only in orientation, then hits on them
      offer(8'd0,   1'b0);
      offer(8'd255, 1'b1);
      offer(8'd0,   1'b1);
      offer(8'd255, 1'b0);
      offer(8'd0,   1'b0);
      offer(8'd255, 1'b1);
      offer(8'd128, 1'b0);
      offer(8'd127, 1'b1);
      offer(8'd1,   1'b0);
      offer(8'd254, 1'b1);
      offer(8'd128, 1'b0);
      offer(8'd0,   1'b1);
      offer(8'd254, 1'b1);

      for (n = 0; n < RANDOM_ITEMS / 3; n++) offer_random();
      gap_pct    = 76;
      stall_pct <= 10;
      for (n = 0; n < RANDOM_ITEMS / 3; n++) offer_random();
      gap_pct     = 0;
      stall_pct  <= 0;
      hold_armed <= 1'b1;
      for (n = 0; n < RANDOM_ITEMS / 3; n++) offer_random();

      offer(8'h5A, 1'b0);
      offer(8'h3C, 1'b1);
      offer(8'hC3, 1'b0);
      offer(8'h96, 1'b1);
      req_valid <= 1'b0;
      @(posedge clock);

      while (outstanding != 0) @(posedge clock);
      repeat (CACHE_SLOTS + 8) @(posedge clock);
      $display("lookups checked: %0d hits, %0d misses, %0d of them evictions of a full cache",
               hit_count, miss_count, evict_count);
      $display("evictions that skipped slots gone stale past half the stamp range: %0d",
               aged_out_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ltc_pkg.sv
hdl/ltc_cell.sv
hdl/lru_tag_cache_lookup_core.sv
dv/lru_tag_cache_lookup_checker.sv
dv/tb_lru_tag_cache_lookup_core.sv
